// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DUR_BITS       = 32;
  localparam int BUTTON_BITS    = 6;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LONG_PRESS_TICKS = 2'd0,
    CFG_DEBOUNCE_TICKS   = 2'd1,
    CFG_MIN_PRESS_TICKS  = 2'd2,
    CFG_BUTTON_NUMBER    = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    EV_SHORT   = 2'd0,
    EV_LONG    = 2'd1,
    EV_LONG_UP = 2'd2
  } event_kind_t;

  localparam logic [15:0] LONG_PRESS_RESET = 16'd1500;
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] MIN_PRESS_RESET  = 16'd50;
  localparam logic [BUTTON_BITS-1:0] BUTTON_RESET = '0;

  typedef struct packed {
    logic [BUTTON_BITS-1:0] source_button;
    logic [DUR_BITS-1:0]    duration;
    event_kind_t            event_kind;
  } result_t;

  typedef struct packed {
    logic is_down;
    logic hold_running;
    logic settled;
    logic lockout_busy;
  } status_t;

endpackage

// ===== rtl/button_press_classifier.sv =====
// Button press classifier. Each input transfer is a time tick (s_tuser = 0) or
// a pin level change (s_tuser = 1, s_tdata[0] = 1 for pressed). Holding the
// button for long_press_ticks raises a long-press event; a release raises a
// short-press or long-press-released event with the held duration and then
// ignores pin changes for debounce_ticks ticks (at least one). Events shorter
// than min_press_ticks are dropped. One input transfer is taken every cycle
// while s_tready is high; its result, if any, goes to the output register
// that drives the master side. When the master side stalls, one further
// result is held in a skid register and s_tready drops until it drains. Config
// writes (cfg_index / cfg_data, always ready) are meant for idle periods only.
module button_press_classifier import bpc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [0] pressed, [7:1] zero
  input  logic                      s_tuser,   // [0] action
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,   // [31:0] duration, [37:32] source_button
  output logic [1:0]                m_tuser,   // [1:0] event_kind
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic    accept;
  logic    res_valid;
  result_t res;
  status_t status;

  logic    out_valid;
  result_t out_reg;
  logic    skid_valid;
  result_t skid_reg;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;

  bpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index_t'(cfg_index)),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .action    (s_tuser),
    .pressed   (s_tdata[0]),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      // skid full means no input was accepted, so no new result competes
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_reg.source_button, out_reg.duration};
  assign m_tuser  = out_reg.event_kind;

  // skid only fills behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  // a new result never arrives while the skid register is occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !skid_valid)
    else $error("result produced with skid register full");

  // lockout running means pin changes are still being ignored
  a_lockout_unsettled: assert property (@(posedge clk) disable iff (rst)
    status.lockout_busy |-> !status.settled)
    else $error("lockout running while settled");

  // hold timer only runs during a press
  a_hold_while_down: assert property (@(posedge clk) disable iff (rst)
    status.hold_running |-> status.is_down)
    else $error("hold timer running with button up");

endmodule

// ===== rtl/bpc_core.sv =====
module bpc_core import bpc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  cfg_index_t                cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      accept,
  input  logic                      action,
  input  logic                      pressed,
  output logic                      res_valid,
  output result_t                   res,
  output status_t                   status
);

  logic [15:0]            long_press_ticks;
  logic [15:0]            debounce_ticks;
  logic [15:0]            min_press_ticks;
  logic [BUTTON_BITS-1:0] button_number;

  logic [TIME_BITS-1:0] time_now, time_now_next;
  logic [TIME_BITS-1:0] press_start, press_start_next;
  logic                 is_down, is_down_next;
  logic                 hold_running, hold_running_next;
  logic                 long_seen, long_seen_next;
  logic                 settled, settled_next;
  logic [15:0]          lockout_count, lockout_count_next;

  logic [TIME_BITS-1:0] time_inc;
  logic [TIME_BITS-1:0] dt;
  logic                 fire;
  event_kind_t          kind;
  logic [DUR_BITS-1:0]  dur;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
      debounce_ticks   <= DEBOUNCE_RESET;
      min_press_ticks  <= MIN_PRESS_RESET;
      button_number    <= BUTTON_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        CFG_MIN_PRESS_TICKS:  min_press_ticks  <= cfg_data;
        CFG_BUTTON_NUMBER:    button_number    <= cfg_data[BUTTON_BITS-1:0];
      endcase
    end
  end

  assign time_inc = time_now + TIME_BITS'(1);
  // a tick measures against the advanced time, a release against the current one
  assign dt = (action ? time_now : time_inc) - press_start;

  generate
    if (TIME_BITS >= DUR_BITS) begin : g_cut
      assign dur = dt[DUR_BITS-1:0];
    end else begin : g_ext
      assign dur = {{(DUR_BITS-TIME_BITS){1'b0}}, dt};
    end
  endgenerate

  always_comb begin
    time_now_next      = time_now;
    press_start_next   = press_start;
    is_down_next       = is_down;
    hold_running_next  = hold_running;
    long_seen_next     = long_seen;
    settled_next       = settled;
    lockout_count_next = lockout_count;
    fire               = 1'b0;
    kind               = EV_SHORT;
    if (accept) begin
      if (!action) begin
        time_now_next = time_inc;
        if (lockout_count != 16'd0) begin
          lockout_count_next = lockout_count - 16'd1;
          if (lockout_count == 16'd1) begin
            settled_next = 1'b1;
          end
        end
        if (hold_running && is_down &&
            dt >= {{(TIME_BITS-16){1'b0}}, long_press_ticks}) begin
          hold_running_next = 1'b0;
          long_seen_next    = 1'b1;
          fire              = 1'b1;
          kind              = EV_LONG;
        end
      end else if (settled) begin
        if (pressed) begin
          if (!is_down && !hold_running) begin
            is_down_next      = 1'b1;
            press_start_next  = time_now;
            hold_running_next = 1'b1;
          end
        end else if (is_down) begin
          fire               = 1'b1;
          if (long_seen) begin
            kind = EV_LONG_UP;
          end
          is_down_next       = 1'b0;
          hold_running_next  = 1'b0;
          long_seen_next     = 1'b0;
          settled_next       = 1'b0;
          lockout_count_next = (debounce_ticks == 16'd0) ? 16'd1 : debounce_ticks;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now      <= '0;
      press_start   <= '0;
      is_down       <= 1'b0;
      hold_running  <= 1'b0;
      long_seen     <= 1'b0;
      settled       <= 1'b1;
      lockout_count <= '0;
    end else begin
      time_now      <= time_now_next;
      press_start   <= press_start_next;
      is_down       <= is_down_next;
      hold_running  <= hold_running_next;
      long_seen     <= long_seen_next;
      settled       <= settled_next;
      lockout_count <= lockout_count_next;
    end
  end

  assign res_valid = fire && !(dt < {{(TIME_BITS-16){1'b0}}, min_press_ticks});
  assign res.event_kind    = kind;
  assign res.duration      = dur;
  assign res.source_button = button_number;

  assign status.is_down      = is_down;
  assign status.hold_running = hold_running;
  assign status.settled      = settled;
  assign status.lockout_busy = (lockout_count != 16'd0);

endmodule

// ===== test/tb.sv =====
module tb;
  import bpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Input item codes (s_tuser carries the action, s_tdata[0] the pin level)
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_CHANGE = 1'b1;
  localparam logic PIN_UP     = 1'b0;
  localparam logic PIN_DOWN   = 1'b1;

  localparam int HOLD_CYCLES   = 80;   // long receiver hold-off
  localparam int RANDOM_PHASES = 2;
  localparam int PHASE_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;             // [0] pressed, [7:1] zero
  logic        s_tuser = ACT_TICK;       // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;                  // [31:0] duration, [37:32] source_button
  logic [1:0]  m_tuser;                  // [1:0] event_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = CFG_LONG_PRESS_TICKS;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  button_press_classifier DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Classifier shadow state. Starts at reset values; updated only from the
  // transfers seen at the ports, so it tracks whatever the stimulus did.
  // ---------------------------------------------------------------------------
  logic [15:0]            long_cfg = LONG_PRESS_RESET;
  logic [15:0]            debounce_cfg = DEBOUNCE_RESET;
  logic [15:0]            min_cfg = MIN_PRESS_RESET;
  logic [BUTTON_BITS-1:0] button_cfg = BUTTON_RESET;

  logic [DUR_BITS-1:0] tick_now = '0;
  logic [DUR_BITS-1:0] press_time = '0;
  logic                btn_down = 1'b0;
  logic                hold_armed = 1'b0;
  logic                long_fired = 1'b0;
  logic                pin_settled = 1'b1;
  logic [15:0]         lockout_left = '0;

  result_t pending_events[$];   // events still owed by the block, oldest first
  int      mismatch_count = 0;

  // Queue an event unless it is too short to report.
  function automatic void report_press(event_kind_t kind, logic [DUR_BITS-1:0] held);
    result_t ev;
    if (held >= {16'd0, min_cfg}) begin
      ev.event_kind    = kind;
      ev.duration      = held;
      ev.source_button = button_cfg;
      pending_events.push_back(ev);
    end
  endfunction

  function automatic void classify_input(logic act, logic pin);
    logic [DUR_BITS-1:0] held;
    if (act == ACT_TICK) begin
      tick_now = tick_now + 1'b1;
      if (lockout_left != 0) begin
        lockout_left = lockout_left - 1'b1;
        if (lockout_left == 0) pin_settled = 1'b1;
      end
      if (hold_armed && btn_down) begin
        held = tick_now - press_time;
        if (held >= {16'd0, long_cfg}) begin
          hold_armed = 1'b0;
          long_fired = 1'b1;
          report_press(EV_LONG, held);
        end
      end
    end else if (pin_settled) begin
      if (pin == PIN_DOWN) begin
        // second press while already down is dropped
        if (!btn_down && !hold_armed) begin
          btn_down   = 1'b1;
          press_time = tick_now;
          hold_armed = 1'b1;
        end
      end else if (btn_down) begin
        held = tick_now - press_time;
        if (long_fired) begin
          report_press(EV_LONG_UP, held);
        end else begin
          report_press(EV_SHORT, held);
        end
        btn_down     = 1'b0;
        hold_armed   = 1'b0;
        long_fired   = 1'b0;
        pin_settled  = 1'b0;
        // a zero lockout still blocks for one tick
        lockout_left = (debounce_cfg != 0) ? debounce_cfg : 16'd1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Port monitor: checks each result transfer against the oldest pending event,
  // then feeds accepted input and config transfers to the shadow state.
  // All signals are sampled at the rising edge, before any NBA update.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event: kind %0d duration %0d button %0d",
                   $time, m_tuser, m_tdata[31:0], m_tdata[37:32]);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          if (m_tuser !== want.event_kind) begin
            $display("%0t: event_kind expected %0d actual %0d",
                     $time, want.event_kind, m_tuser);
            mismatch_count++;
          end
          if (m_tdata[31:0] !== want.duration) begin
            $display("%0t: duration expected %0d actual %0d",
                     $time, want.duration, m_tdata[31:0]);
            mismatch_count++;
          end
          if (m_tdata[37:32] !== want.source_button) begin
            $display("%0t: source_button expected %0d actual %0d",
                     $time, want.source_button, m_tdata[37:32]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) classify_input(s_tuser, s_tdata[0]);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LONG_PRESS_TICKS: long_cfg = cfg_data;
          CFG_DEBOUNCE_TICKS:   debounce_cfg = cfg_data;
          CFG_MIN_PRESS_TICKS:  min_cfg = cfg_data;
          CFG_BUTTON_NUMBER:    button_cfg = cfg_data[BUTTON_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern that switches at random among its modes
  // (always ready, mostly ready, mostly stalled). A bump of hold_req forces a
  // long hold-off so the block's output and skid registers fill and s_tready
  // drops while the sender keeps offering.
  // ---------------------------------------------------------------------------
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(8, 64);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: bursts of random length separated by random gaps. Gaps can be
  // switched off for tick runs. All tasks enter and leave on a rising edge.
  // ---------------------------------------------------------------------------
  bit gaps_on = 1'b1;
  int burst_left = 0;

  task automatic send_item(input logic act, input logic pin);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, pin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(ACT_TICK, 1'($urandom_range(0, 1)));
  endtask

  // Stop offering and wait until every owed event is out, and then until an
  // input still in the pipe that owes nothing has passed.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] long_val, input logic [15:0] deb_val,
                           input logic [15:0] min_val, input logic [5:0] btn_val);
    cfg_index_t  regs[4] = '{CFG_LONG_PRESS_TICKS, CFG_DEBOUNCE_TICKS,
                             CFG_MIN_PRESS_TICKS, CFG_BUTTON_NUMBER};
    logic [15:0] vals[4];
    vals = '{long_val, deb_val, min_val, {10'd0, btn_val}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: short press of 60, a press inside the lockout, then a
  // 10-tick press that falls below the default minimum.
  task automatic test_reset_defaults();
    send_item(ACT_CHANGE, PIN_DOWN);
    send_ticks(60);
    send_item(ACT_CHANGE, PIN_UP);
    send_item(ACT_CHANGE, PIN_DOWN);      // inside lockout, ignored
    send_ticks(50);
    send_item(ACT_CHANGE, PIN_DOWN);
    send_ticks(10);
    send_item(ACT_CHANGE, PIN_UP);        // duration 10 < 50, dropped
    send_ticks(50);
    drain();
  endtask

  // Zero long/debounce/min: zero-length press, long fires on first tick,
  // redundant presses and releases are dropped, pin ignored on ticks.
  task automatic test_zero_settings();
    configure(16'd0, 16'd0, 16'd0, 6'd63);
    send_item(ACT_CHANGE, PIN_DOWN);
    send_item(ACT_CHANGE, PIN_UP);        // short, duration 0
    send_item(ACT_CHANGE, PIN_DOWN);      // locked out
    send_item(ACT_TICK, PIN_UP);          // lockout of one tick ends
    send_item(ACT_CHANGE, PIN_DOWN);
    send_item(ACT_CHANGE, PIN_DOWN);      // already down
    send_item(ACT_TICK, PIN_DOWN);        // long, duration 1
    send_item(ACT_TICK, PIN_UP);
    send_item(ACT_CHANGE, PIN_DOWN);      // still down
    send_item(ACT_CHANGE, PIN_UP);        // long released, duration 2
    send_item(ACT_TICK, PIN_DOWN);
    send_item(ACT_CHANGE, PIN_UP);        // release while up
    send_item(ACT_TICK, PIN_DOWN);
    drain();
  endtask

  // Minimum duration boundary, and a dropped long press that still arms the
  // long-released kind.
  task automatic test_min_duration();
    configure(16'd4, 16'd1, 16'd3, 6'd21);
    send_item(ACT_CHANGE, PIN_DOWN);
    send_ticks(2);
    send_item(ACT_CHANGE, PIN_UP);        // duration 2 < 3, dropped
    send_ticks(1);
    send_item(ACT_CHANGE, PIN_DOWN);
    send_ticks(3);
    send_item(ACT_CHANGE, PIN_UP);        // exactly 3, kept
    send_ticks(1);
    drain();
    configure(16'd4, 16'd2, 16'd5, 6'd42);
    send_item(ACT_CHANGE, PIN_DOWN);
    send_ticks(5);                        // long at 4 is dropped
    send_item(ACT_CHANGE, PIN_UP);        // long released at 5
    send_ticks(2);
    drain();
  endtask

  // Full-scale registers: a 65535-tick long threshold is not reached by a
  // short press, and a 65535-tick lockout keeps ignoring presses. The lockout
  // is left running, so this runs last.
  task automatic test_full_scale();
    send_ticks(10);                       // end any lockout left by earlier noise
    send_item(ACT_CHANGE, PIN_UP);
    send_ticks(10);
    drain();
    configure(16'hFFFF, 16'hFFFF, 16'd0, 6'd42);
    gaps_on = 1'b0;
    send_item(ACT_CHANGE, PIN_DOWN);
    send_ticks(40);
    send_item(ACT_CHANGE, PIN_UP);        // short, duration 40
    send_item(ACT_CHANGE, PIN_DOWN);      // locked out
    send_ticks(20);
    send_item(ACT_CHANGE, PIN_DOWN);      // still locked out
    gaps_on = 1'b1;
    drain();
  endtask

  // Dense results against a long receiver hold-off.
  task automatic test_backpressure();
    configure(16'd1, 16'd1, 16'd0, 6'd7);
    hold_req <= hold_req + 1;
    repeat (20) begin
      send_item(ACT_CHANGE, PIN_DOWN);
      send_item(ACT_TICK, PIN_UP);        // long
      send_item(ACT_CHANGE, PIN_UP);      // long released
      send_item(ACT_TICK, PIN_UP);
      send_item(ACT_CHANGE, PIN_DOWN);
      send_item(ACT_CHANGE, PIN_UP);      // short, duration 0
      send_item(ACT_TICK, PIN_DOWN);
    end
    drain();
  endtask

  // Random settings per phase; mostly whole press/hold/release/settle
  // sequences with random lengths around the thresholds, some raw noise.
  task automatic test_random_traffic();
    int          sent;
    int          hold_len;
    int          rest_len;
    logic [15:0] long_val;
    logic [15:0] deb_val;
    logic [15:0] min_val;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      long_val = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
      deb_val  = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
      min_val  = 16'($urandom_range(0, 20));
      configure(long_val, deb_val, min_val, 6'($urandom_range(0, 63)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          hold_len = $urandom_range(0, 2 * long_val + 4);
          rest_len = $urandom_range(0, deb_val + 3);
          send_item(ACT_CHANGE, PIN_DOWN);
          send_ticks(hold_len);
          send_item(ACT_CHANGE, PIN_UP);
          send_ticks(rest_len);
          sent += hold_len + rest_len + 2;
        end
      end
      drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_settings();
    test_min_duration();
    test_backpressure();
    test_random_traffic();
    test_full_scale();
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
